// File: sv/crc32_packet_deframer_macros.svh
// Assertion macros for the packet deframer.
// Each macro expects signals named clock and reset at the point of use.
`ifndef CRC32_PACKET_DEFRAMER_MACROS_SVH
`define CRC32_PACKET_DEFRAMER_MACROS_SVH

// same-cycle implication
`define CPD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CPD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/cpd_pkg.sv
// Shared types, constants and the CRC byte update for the packet deframer.
// No dependencies.
package cpd_pkg;

   localparam int PKT_LEN  = 24;
   localparam int CRC_SPAN = 20;

   localparam logic [31:0] CRC_POLY_REFL = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT      = 32'hFFFFFFFF;
   localparam logic [31:0] CRC_FINAL_XOR = 32'h00000000;
   localparam logic [15:0] SYNC_RESET    = 16'hAA55;

   localparam logic       REG_SYNC_WORD = 1'b0;
   localparam logic       OUTCOME_OK      = 1'b0;
   localparam logic       OUTCOME_CRC_ERR = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_SCAN = 5'b00010,
      ST_CRC  = 5'b00100,
      ST_EMIT = 5'b01000,
      ST_WAIT = 5'b10000
   } cpd_state_type;

   typedef struct packed {
      logic append;
      logic drop_one;
      logic crc_start;
      logic crc_step;
      logic emit;
   } cpd_cmd_type;

   typedef struct packed {
      logic fill_ge2;
      logic pair_match;
      logic full;
      logic crc_last;
      logic rsp_busy;
   } cpd_status_type;

   // reflected CRC-32, one byte, LSB first
   function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] data);
      logic [31:0] c;
      c = crc_in ^ {24'h000000, data};
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// File: sv/cpd_csr.sv
// APB-style register file for the packet deframer: holds the sync word.
// Depends on cpd_pkg.
module cpd_csr
   import cpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output logic [15:0] sync_word
);

   logic [15:0] sync_ff;
   logic [15:0] sync_in;
   logic        wr_hit;

   assign csr_pready = 1'b1;
   assign wr_hit = csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == REG_SYNC_WORD);

   always_comb begin
      sync_in = sync_ff;
      if (wr_hit) begin
         sync_in = csr_pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff <= SYNC_RESET;
      end else begin
         sync_ff <= sync_in;
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_SYNC_WORD: csr_prdata = {16'h0000, sync_ff};
         default:       csr_prdata = 32'h00000000;
      endcase
   end

   assign sync_word = sync_ff;

endmodule

// File: sv/cpd_ctrl.sv
// Sequencer for the packet deframer: append, scan, CRC walk, result.
// Depends on cpd_pkg.
module cpd_ctrl
   import cpd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  cpd_status_type status,
   output cpd_cmd_type    cmd
);

   cpd_state_type state_ff;
   cpd_state_type state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.append = 1'b1;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!status.fill_ge2) begin
               state_in = ST_IDLE;
            end else if (!status.pair_match) begin
               cmd.drop_one = 1'b1;
            end else if (!status.full) begin
               state_in = ST_IDLE;
            end else begin
               cmd.crc_start = 1'b1;
               state_in      = ST_CRC;
            end
         end
         ST_CRC: begin
            cmd.crc_step = 1'b1;
            if (status.crc_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // hold until the output register is free
            if (!status.rsp_busy) begin
               cmd.emit = 1'b1;
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            // window shift from emit settles, then rescan
            state_in = ST_SCAN;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: sv/cpd_dp.sv
// Datapath for the packet deframer: byte window, fill count, CRC, output register.
// Depends on cpd_pkg.
module cpd_dp
   import cpd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic [7:0]     rx_byte,
   input  logic [15:0]    sync_word,
   input  cpd_cmd_type    cmd,
   output cpd_status_type status,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output logic [143:0]   rsp_tdata,
   output logic [0:0]     rsp_tuser
);

   localparam logic [4:0] LEN  = 5'(PKT_LEN);
   localparam logic [4:0] LAST = 5'(CRC_SPAN - 1);

   logic [7:0]   win_ff [PKT_LEN];
   logic [7:0]   win_in [PKT_LEN];
   logic [4:0]   fill_ff, fill_in;
   logic [31:0]  crc_ff, crc_in;
   logic [4:0]   cidx_ff, cidx_in;
   logic         valid_ff, valid_in;
   logic [143:0] data_ff, data_in;
   logic         user_ff, user_in;
   logic [4:0]   wr_idx;
   logic [31:0]  rx_crc;
   logic         crc_ok;
   logic [143:0] fields;

   assign wr_idx = (fill_ff >= LEN) ? 5'd0 : fill_ff;
   assign rx_crc = {win_ff[23], win_ff[22], win_ff[21], win_ff[20]};
   assign crc_ok = (rx_crc == (crc_ff ^ CRC_FINAL_XOR));

   // payload words little-endian, status in the low bits
   assign fields = {win_ff[19], win_ff[18], win_ff[17], win_ff[16],
                    win_ff[15], win_ff[14], win_ff[13], win_ff[12],
                    win_ff[11], win_ff[10], win_ff[9],  win_ff[8],
                    win_ff[7],  win_ff[6],  win_ff[5],  win_ff[4],
                    win_ff[3],  win_ff[2]};

   always_comb begin
      win_in  = win_ff;
      fill_in = fill_ff;
      crc_in  = crc_ff;
      cidx_in = cidx_ff;
      if (cmd.append) begin
         win_in[wr_idx] = rx_byte;
         fill_in        = wr_idx + 5'd1;
      end
      if (cmd.drop_one) begin
         for (int i = 0; i < PKT_LEN - 1; i++) begin
            win_in[i] = win_ff[i + 1];
         end
         fill_in = fill_ff - 5'd1;
      end
      if (cmd.crc_start) begin
         crc_in  = CRC_INIT;
         cidx_in = 5'd0;
      end
      if (cmd.crc_step) begin
         crc_in  = crc_byte(crc_ff, win_ff[cidx_ff]);
         cidx_in = cidx_ff + 5'd1;
      end
      if (cmd.emit) begin
         if (crc_ok) begin
            fill_in = 5'd0;
         end else begin
            for (int i = 0; i < PKT_LEN - 2; i++) begin
               win_in[i] = win_ff[i + 2];
            end
            fill_in = fill_ff - 5'd2;
         end
      end
   end

   always_comb begin
      valid_in = valid_ff && !rsp_tready;
      data_in  = data_ff;
      user_in  = user_ff;
      if (cmd.emit) begin
         valid_in = 1'b1;
         user_in  = crc_ok ? OUTCOME_OK : OUTCOME_CRC_ERR;
         data_in  = crc_ok ? fields : '0;
      end
   end

   always_ff @(posedge clock) begin
      win_ff  <= win_in;
      cidx_ff <= cidx_in;
      data_ff <= data_in;
      user_ff <= user_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= 5'd0;
         crc_ff   <= CRC_INIT;
         valid_ff <= 1'b0;
      end else begin
         fill_ff  <= fill_in;
         crc_ff   <= crc_in;
         valid_ff <= valid_in;
      end
   end

   assign status.fill_ge2   = (fill_ff >= 5'd2);
   assign status.pair_match = (win_ff[0] == sync_word[7:0]) && (win_ff[1] == sync_word[15:8]);
   assign status.full       = (fill_ff >= LEN);
   assign status.crc_last   = (cidx_ff == LAST);
   assign status.rsp_busy   = valid_ff && !rsp_tready;

   assign rsp_tvalid   = valid_ff;
   assign rsp_tdata    = data_ff;
   assign rsp_tuser[0] = user_ff;

endmodule

// File: sv/crc32_packet_deframer.sv
// Sync-word packet deframer with CRC-32 check, top level.
// Depends on cpd_pkg, cpd_csr, cpd_ctrl, cpd_dp and the assertion macro header.
//
// Usage:
//  - req_*: one received byte per beat. A 24-byte packet is sync word (low byte
//    first), 16-bit status, four little-endian 32-bit payload words and a
//    little-endian reflected CRC-32 (init all ones, no final XOR) over 20 bytes.
//  - rsp_*: at most one beat per input byte. tuser carries the outcome
//    (0 good packet, 1 CRC mismatch with zeroed fields); tdata the fields.
//  - csr_*: APB-style, sync word at byte address 0, reset 0xAA55.
// Sequence: a byte is appended, then scanned; each stray front byte is dropped by
// an extra scan step. A byte that completes a packet is appended, starts the CRC
// walk over 20 bytes (one byte a cycle), waits for a free output register, emits,
// then rescans, dropping bytes one at a time and closing with a scan step.
// Reset empties the window and the output register; the sync word returns to
// its reset value. A stalled receiver holds the result in the output register;
// bytes keep being taken until a new result would need that register.
module crc32_packet_deframer
   import cpd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // req_tdata: [7:0] rx_byte
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,
   // rsp_tdata: [15:0] status_word, [47:16] payload_0, [79:48] payload_1,
   //            [111:80] payload_2, [143:112] payload_3
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [143:0] rsp_tdata,
   // rsp_tuser: [0] outcome
   output logic [0:0]   rsp_tuser,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

`include "crc32_packet_deframer_macros.svh"

   cpd_cmd_type    cmd;
   cpd_status_type status;
   logic [15:0]    sync_word;

   cpd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .sync_word   (sync_word)
   );

   // sequencer: one byte at a time
   cpd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // window, CRC unit and output register
   cpd_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .rx_byte    (req_tdata),
      .sync_word  (sync_word),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // a result is never written over one that is still waiting
   `CPD_ASSERT_NOW(a_emit_free, cmd.emit, !(rsp_tvalid && !rsp_tready), "result overwritten")

   // a taken result with no new one behind it clears the output valid
   `CPD_ASSERT_NEXT(a_rsp_drain, rsp_tvalid && rsp_tready && !cmd.emit, !rsp_tvalid,
                    "result repeated")

   // after a byte is taken the scan runs before the next byte
   `CPD_ASSERT_NEXT(a_one_byte, req_tvalid && req_tready, !req_tready, "byte taken during scan")

endmodule

// File: verif/cpd_frame_checker.sv
// Scoreboard for the CRC-32 packet deframer: watches the byte, result and register ports,
// predicts every result beat and compares it field by field.
// Depends on cpd_pkg for sizes, CRC constants, outcome codes and the register index.
`timescale 1ns / 1ps

module cpd_frame_checker
   import cpd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [7:0]   req_tdata,     // [7:0] rx_byte
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [143:0] rsp_tdata,     // [15:0] status, [47:16] .. [143:112] payload 0..3
   input  logic [0:0]   rsp_tuser,     // [0] outcome
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   input  logic [31:0]  csr_prdata,
   input  logic         csr_pready,
   output int           mismatch_count,
   output int           frames_pending
);

   typedef struct packed {
      logic        outcome;
      logic [15:0] status;
      logic [31:0] word0;
      logic [31:0] word1;
      logic [31:0] word2;
      logic [31:0] word3;
   } frame_result_type;

   logic [7:0]       held [0:PKT_LEN-1];
   int unsigned      held_n;
   logic [15:0]      sync_marker;
   logic [31:0]      last_crc;
   frame_result_type expected_frames[$];

   // reflected CRC-32 over the 20 header and payload bytes of a candidate
   function automatic logic [31:0] window_crc(input int unsigned start);
      logic [31:0] c;
      c = CRC_INIT;
      for (int i = 0; i < CRC_SPAN; i++) begin
         c ^= {24'd0, held[start + i]};
         for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
         end
      end
      return c ^ CRC_FINAL_XOR;
   endfunction

   function automatic logic [31:0] held_word(input int unsigned at);
      return {held[at + 3], held[at + 2], held[at + 1], held[at]};
   endfunction

   // append one byte, then scan from the front as the block does
   task automatic absorb_byte(input logic [7:0] rx);
      int unsigned      n;
      int unsigned      off;
      logic [31:0]      rx_crc;
      frame_result_type r;
      bit               produced;
      if (held_n >= PKT_LEN) held_n = 0;
      held[held_n] = rx;
      held_n++;
      n = held_n;
      off = 0;
      produced = 1'b0;
      while (n - off >= 2) begin
         if (held[off] == sync_marker[7:0] && held[off + 1] == sync_marker[15:8]) begin
            if (n - off < PKT_LEN) break;
            last_crc = window_crc(off);
            rx_crc = held_word(off + CRC_SPAN);
            if (!produced) begin
               if (rx_crc == last_crc) begin
                  r = '{OUTCOME_OK, {held[off + 3], held[off + 2]}, held_word(off + 4),
                        held_word(off + 8), held_word(off + 12), held_word(off + 16)};
               end else begin
                  r = '{OUTCOME_CRC_ERR, 16'h0000, 32'd0, 32'd0, 32'd0, 32'd0};
               end
               expected_frames.push_back(r);
               produced = 1'b1;
            end
            // good packet leaves whole, bad one drops the sync pair and rescans
            off += (rx_crc == last_crc) ? PKT_LEN : 2;
         end else begin
            off += 1;
         end
      end
      if (off > 0) begin
         for (int i = 0; i < n - off; i++) held[i] = held[i + off];
         held_n = n - off;
      end
   endtask

   task automatic compare_field(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      frame_result_type want;
      if (reset) begin
         held_n = 0;
         sync_marker = SYNC_RESET;
         last_crc = CRC_INIT;
         expected_frames.delete();
         mismatch_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pready && csr_paddr[2] == REG_SYNC_WORD) begin
            if (csr_pwrite) sync_marker = csr_pwdata[15:0];
            else compare_field("sync_word read", {16'h0000, sync_marker}, csr_prdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_frames.size() == 0) begin
               $display("%0t: unexpected result beat, expected none, actual outcome %b data %h",
                        $time, rsp_tuser[0], rsp_tdata);
               mismatch_count++;
            end else begin
               want = expected_frames.pop_front();
               compare_field("outcome", 32'(want.outcome), 32'(rsp_tuser[0]));
               compare_field("status_word", 32'(want.status), 32'(rsp_tdata[15:0]));
               compare_field("payload_0", want.word0, rsp_tdata[47:16]);
               compare_field("payload_1", want.word1, rsp_tdata[79:48]);
               compare_field("payload_2", want.word2, rsp_tdata[111:80]);
               compare_field("payload_3", want.word3, rsp_tdata[143:112]);
            end
         end
         if (req_tvalid && req_tready) absorb_byte(req_tdata);
      end
      frames_pending = expected_frames.size();
   end

endmodule

// File: verif/tb_crc32_packet_deframer.sv
// Testbench top for crc32_packet_deframer: clock, reset, byte and register stimulus,
// receiver back-pressure, watchdog and verdict. Checking lives in cpd_frame_checker.
// Depends on cpd_pkg, cpd_frame_checker and the deframer RTL.
`timescale 1ns / 1ps

module tb_crc32_packet_deframer;
   import cpd_pkg::*;

   localparam int         QUIET_LIMIT   = 4000;  // cycles with no beat anywhere
   localparam int         SETTLE_CYCLES = 60;
   localparam int         PHASE_BYTES   = 115;
   localparam int         NUM_PHASES    = 6;
   localparam logic [2:0] ADDR_SYNC     = {REG_SYNC_WORD, 2'b00};
   localparam logic [2:0] ADDR_UNUSED   = 3'b100;  // register index 1, not mapped

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = 8'h00;     // [7:0] rx_byte
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [143:0] rsp_tdata;             // [15:0] status, [47:16] .. [143:112] payload 0..3
   logic [0:0]   rsp_tuser;             // [0] outcome
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [2:0]   csr_paddr = 3'd0;
   logic [31:0]  csr_pwdata = 32'd0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   int           mismatch_count;
   int           frames_pending;
   int           quiet_cycles = 0;
   int           send_idle = 0;         // percent chance of a gap before a byte
   int           recv_stall = 0;        // percent chance rsp_tready is low in a cycle
   logic [15:0]  cur_sync = SYNC_RESET; // marker used to build packets
   logic [7:0]   byte_plan[$];          // bytes still to be sent this phase

   always #6 clock = ~clock;

   crc32_packet_deframer u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   cpd_frame_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .mismatch_count (mismatch_count),
      .frames_pending (frames_pending)
   );

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall);
   end

   // watchdog: any beat on any port restarts the count
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL crc32_packet_deframer");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // payload words lean toward the extremes
   function automatic logic [31:0] pick_word();
      case ($urandom_range(7))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // status is sometimes zero, sometimes all ones, otherwise random
   function automatic logic [15:0] pick_status();
      int roll;
      roll = $urandom_range(9);
      if (roll < 3) return 16'h0000;
      if (roll == 3) return 16'hFFFF;
      return 16'($urandom);
   endfunction

   // queue one packet for the current marker; corrupt flips one bit past the sync pair,
   // keep < PKT_LEN queues only the head of the packet
   task automatic plan_packet(input logic [15:0] status, input logic [31:0] w0,
                              input logic [31:0] w1, input logic [31:0] w2,
                              input logic [31:0] w3, input bit corrupt, input int keep);
      logic [7:0]   pkt [0:PKT_LEN-1];
      logic [127:0] body;
      logic [31:0]  crc;
      int           pos;
      body = {w3, w2, w1, w0};
      pkt[0] = cur_sync[7:0];
      pkt[1] = cur_sync[15:8];
      pkt[2] = status[7:0];
      pkt[3] = status[15:8];
      for (int k = 0; k < 16; k++) pkt[4 + k] = body[8 * k +: 8];
      crc = CRC_INIT;
      for (int k = 0; k < CRC_SPAN; k++) crc = crc_byte(crc, pkt[k]);
      crc ^= CRC_FINAL_XOR;
      for (int k = 0; k < 4; k++) pkt[CRC_SPAN + k] = crc[8 * k +: 8];
      if (corrupt) begin
         pos = $urandom_range(PKT_LEN - 1, 2);
         pkt[pos] ^= 8'(1 << $urandom_range(7));
      end
      for (int k = 0; k < keep; k++) byte_plan.push_back(pkt[k]);
   endtask

   // mostly well-formed packets; the rest exercises the drop and rescan paths
   task automatic plan_random(input int target);
      int roll;
      while (byte_plan.size() < target) begin
         roll = $urandom_range(99);
         if (roll < 45) begin
            plan_packet(pick_status(), pick_word(), pick_word(), pick_word(), pick_word(),
                        1'b0, PKT_LEN);
         end else if (roll < 60) begin
            // bad CRC: error beat, two bytes dropped, the rest rescanned
            plan_packet(pick_status(), pick_word(), pick_word(), pick_word(), pick_word(),
                        1'b1, PKT_LEN);
         end else if (roll < 70) begin
            // stray sync pair in front: the first candidate fails, the rescan finds
            // the real packet two bytes in
            byte_plan.push_back(cur_sync[7:0]);
            byte_plan.push_back(cur_sync[15:8]);
            plan_packet(pick_status(), pick_word(), pick_word(), pick_word(), pick_word(),
                        1'b0, PKT_LEN);
         end else if (roll < 80) begin
            // cut-off packet, the next item lands inside its window
            plan_packet(pick_status(), pick_word(), pick_word(), pick_word(), pick_word(),
                        1'b0, $urandom_range(PKT_LEN - 1, 2));
         end else begin
            // line noise, biased toward the marker's low byte
            repeat ($urandom_range(8, 1)) begin
               byte_plan.push_back(($urandom_range(3) == 0) ? cur_sync[7:0] : 8'($urandom));
            end
         end
      end
   endtask

   // one beat per planned byte; tvalid stays high across back-to-back bytes
   task automatic send_planned();
      logic [7:0] b;
      while (byte_plan.size() != 0) begin
         b = byte_plan.pop_front();
         if ($urandom_range(99) < send_idle) begin
            req_tvalid <= 1'b0;
            do @(posedge clock); while ($urandom_range(99) < send_idle);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= b;
         do @(posedge clock); while (!req_tready);
      end
      req_tvalid <= 1'b0;
   endtask

   // setup cycle, access cycle, then a pause with the bus released
   task automatic csr_access(input bit wr, input logic [2:0] addr, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // drain the results, then give a byte that causes no result time to finish
   task automatic finish_phase();
      @(negedge clock);
      while (frames_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int send_pct [NUM_PHASES];
      int stall_pct [NUM_PHASES];
      send_pct  = '{0, 84, 0, 12, 0, 12};
      stall_pct = '{0, 0, 84, 12, 0, 12};
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         send_idle  = send_pct[ph];
         recv_stall = stall_pct[ph];
         // markers: reset value, all zeros, all ones, random; phase 4 writes the
         // unmapped index, which must leave the marker alone
         if (ph == 4) begin
            csr_access(1'b1, ADDR_UNUSED, $urandom);
         end else if (ph != 0) begin
            cur_sync = (ph == 1) ? 16'h0000 : (ph == 2) ? 16'hFFFF : 16'($urandom);
            csr_access(1'b1, ADDR_SYNC, {16'($urandom), cur_sync});
         end
         csr_access(1'b0, ADDR_SYNC, 32'd0);

         if (ph == 0) begin
            // extremes: noise bytes 00 and FF, then a good packet with all-ones status
            // and payload words alternating between zero and all ones
            byte_plan.push_back(8'h00);
            byte_plan.push_back(8'hFF);
            plan_packet(16'hFFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
                        32'hFFFF_FFFF, 1'b0, PKT_LEN);
         end
         plan_random(PHASE_BYTES);
         send_planned();
         finish_phase();
      end

      @(negedge clock);
      if (mismatch_count == 0 && frames_pending == 0) begin
         $display("PASS crc32_packet_deframer");
      end else begin
         $display("FAIL crc32_packet_deframer");
      end
      $finish;
   end

endmodule

// File: crc32_packet_deframer.f
+incdir+sv
sv/cpd_pkg.sv
sv/cpd_csr.sv
sv/cpd_ctrl.sv
sv/cpd_dp.sv
sv/crc32_packet_deframer.sv
verif/cpd_frame_checker.sv
verif/tb_crc32_packet_deframer.sv
